/* rtl/core/ppwm_pkg.sv */
`default_nettype none
package ppwm_pkg;

    // counter width and number of populated channels
    localparam int COUNT_WIDTH  = 16;
    localparam int NUM_CHANNELS = 4;
    localparam int DATA_WIDTH   = 16;
    localparam int PWM_WIDTH    = 4;
    localparam int EXT_WIDTH    = 48;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [DATA_WIDTH-1:0]  data_t;

    // item operation codes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // register map
    localparam logic [3:0] ADDR_CTRL     = 4'd0;
    localparam logic [3:0] ADDR_IRQ_EN   = 4'd1;
    localparam logic [3:0] ADDR_STATUS   = 4'd2;
    localparam logic [3:0] ADDR_PRESCALE = 4'd3;
    localparam logic [3:0] ADDR_RELOAD   = 4'd4;
    localparam logic [3:0] ADDR_COUNT    = 4'd5;
    localparam logic [3:0] ADDR_CHAN     = 4'd6;
    localparam logic [3:0] ADDR_CMP1     = 4'd7;

    // ctrl register bit positions
    localparam int CTRL_EN_BIT  = 0;
    localparam int CTRL_DIR_BIT = 4;

    // channel control field layout
    localparam int CH_MODE_BIT = 0;
    localparam int CH_POL_BIT  = 1;
    localparam int CH_EN_BIT   = 2;
    localparam int CH_BITS     = 3;

    // bus data to counter width, zero extended or truncated
    function automatic cnt_t to_cnt(input data_t d);
        logic [EXT_WIDTH-1:0] w;
        w = EXT_WIDTH'(d);
        return w[COUNT_WIDTH-1:0];
    endfunction

    // counter value to bus data, low bits
    function automatic data_t to_data(input cnt_t c);
        logic [EXT_WIDTH-1:0] w;
        w = EXT_WIDTH'(c);
        return w[DATA_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/core/prescaled_pwm_timer.sv */
`default_nettype none
// Prescaled up/down timer with PWM channels and a register port.
// Input channel (s_*): each item is a timer tick (op 0), a register write
// (op 1) or a register read (op 2); op 3 changes nothing.
// Result channel (m_*): exactly one item per input item, in order, carrying
// the read data (zero unless a read), the update interrupt level and the
// PWM levels, all as they stand after the input item has been applied.
// The result is registered: valid in the cycle after the item is accepted.
// Throughput: one item per cycle while results are taken; state update and
// result computation take a single pass of logic (prescale compare, counter
// add/compare, per-channel compare) into the state and result registers.
// A stalled receiver holds the result register; s_ready is high whenever
// the result register is empty or is being taken in the same cycle, so
// input is only held off while a result waits.
// Reset (aresetn low, synchronous): timer disabled, up count, all flags,
// counters, channel controls and compares zero, reload all ones, no result
// pending.
module prescaled_pwm_timer
    import ppwm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_op,
    input  wire logic [3:0]           s_addr,
    input  wire logic [15:0]          s_wdata,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [15:0]               m_rdata,
    output logic                      m_irq,
    output logic [PWM_WIDTH-1:0]      m_pwm_out
);

    // timer state
    logic                       enable_reg, enable_next;
    logic                       down_reg, down_next;
    logic                       irq_en_reg, irq_en_next;
    logic                       flag_reg, flag_next;
    cnt_t                       psc_val_reg, psc_val_next;
    cnt_t                       reload_reg, reload_next;
    cnt_t                       count_reg, count_next;
    cnt_t                       psc_cnt_reg, psc_cnt_next;
    logic [CH_BITS-1:0]         chan_reg [NUM_CHANNELS];
    logic [CH_BITS-1:0]         chan_next [NUM_CHANNELS];
    cnt_t                       cmp_reg [NUM_CHANNELS];
    cnt_t                       cmp_next [NUM_CHANNELS];

    // result register
    logic                       m_valid_reg;
    data_t                      rdata_reg, rdata_next;
    logic                       irq_reg, irq_next;
    logic [PWM_WIDTH-1:0]       pwm_reg, pwm_next;

    logic                       accept;
    op_t                        op;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign op      = op_t'(s_op);

    // next state for the accepted item
    always_comb begin
        enable_next  = enable_reg;
        down_next    = down_reg;
        irq_en_next  = irq_en_reg;
        flag_next    = flag_reg;
        psc_val_next = psc_val_reg;
        reload_next  = reload_reg;
        count_next   = count_reg;
        psc_cnt_next = psc_cnt_reg;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            chan_next[c] = chan_reg[c];
            cmp_next[c]  = cmp_reg[c];
        end
        if (accept) begin
            case (op)
                OP_TICK: begin
                    if (enable_reg) begin
                        if (psc_cnt_reg >= psc_val_reg) begin
                            psc_cnt_next = '0;
                            // main counter step
                            if (down_reg) begin
                                if (count_reg == '0) begin
                                    count_next = reload_reg;
                                    flag_next  = 1'b1;
                                end else begin
                                    count_next = count_reg - cnt_t'(1);
                                end
                            end else begin
                                if (count_reg >= reload_reg) begin
                                    count_next = '0;
                                    flag_next  = 1'b1;
                                end else begin
                                    count_next = count_reg + cnt_t'(1);
                                end
                            end
                        end else begin
                            psc_cnt_next = psc_cnt_reg + cnt_t'(1);
                        end
                    end
                end
                OP_WRITE: begin
                    unique case (s_addr)
                        ADDR_CTRL: begin
                            enable_next = s_wdata[CTRL_EN_BIT];
                            down_next   = s_wdata[CTRL_DIR_BIT];
                        end
                        ADDR_IRQ_EN:   irq_en_next = s_wdata[0];
                        ADDR_STATUS: begin
                            if (!s_wdata[0]) begin
                                flag_next = 1'b0;
                            end
                        end
                        ADDR_PRESCALE: psc_val_next = to_cnt(s_wdata);
                        ADDR_RELOAD:   reload_next  = to_cnt(s_wdata);
                        ADDR_COUNT:    count_next   = to_cnt(s_wdata);
                        ADDR_CHAN: begin
                            for (int c = 0; c < NUM_CHANNELS; c++) begin
                                chan_next[c] = s_wdata[CH_BITS*c +: CH_BITS];
                            end
                        end
                        default: begin
                            for (int c = 0; c < NUM_CHANNELS; c++) begin
                                if (s_addr == ADDR_CMP1 + 4'(c)) begin
                                    cmp_next[c] = to_cnt(s_wdata);
                                end
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // read data for the accepted item
    always_comb begin
        rdata_next = '0;
        if (op == OP_READ) begin
            unique case (s_addr)
                ADDR_CTRL: begin
                    rdata_next[CTRL_EN_BIT]  = enable_reg;
                    rdata_next[CTRL_DIR_BIT] = down_reg;
                end
                ADDR_IRQ_EN:   rdata_next[0] = irq_en_reg;
                ADDR_STATUS:   rdata_next[0] = flag_reg;
                ADDR_PRESCALE: rdata_next = to_data(psc_val_reg);
                ADDR_RELOAD:   rdata_next = to_data(reload_reg);
                ADDR_COUNT:    rdata_next = to_data(count_reg);
                ADDR_CHAN: begin
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        rdata_next[CH_BITS*c +: CH_BITS] = chan_reg[c];
                    end
                end
                default: begin
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (s_addr == ADDR_CMP1 + 4'(c)) begin
                            rdata_next = to_data(cmp_reg[c]);
                        end
                    end
                end
            endcase
        end
    end

    // interrupt and pwm levels from the updated state
    always_comb begin
        logic lvl;
        irq_next = flag_next && irq_en_next;
        pwm_next = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            lvl = chan_next[c][CH_MODE_BIT] && (count_next < cmp_next[c]);
            lvl = lvl ^ chan_next[c][CH_POL_BIT];
            pwm_next[c] = lvl && chan_next[c][CH_EN_BIT];
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            down_reg    <= 1'b0;
            irq_en_reg  <= 1'b0;
            flag_reg    <= 1'b0;
            psc_val_reg <= '0;
            reload_reg  <= '1;
            count_reg   <= '0;
            psc_cnt_reg <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                chan_reg[c] <= '0;
                cmp_reg[c]  <= '0;
            end
        end else begin
            enable_reg  <= enable_next;
            down_reg    <= down_next;
            irq_en_reg  <= irq_en_next;
            flag_reg    <= flag_next;
            psc_val_reg <= psc_val_next;
            reload_reg  <= reload_next;
            count_reg   <= count_next;
            psc_cnt_reg <= psc_cnt_next;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                chan_reg[c] <= chan_next[c];
                cmp_reg[c]  <= cmp_next[c];
            end
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
            pwm_reg   <= pwm_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_rdata   = rdata_reg;
    assign m_irq     = irq_reg;
    assign m_pwm_out = pwm_reg;

endmodule
`default_nettype wire
